/* src/spd_pkg.sv */
package spd_pkg;

  localparam int unsigned MAX_WINDOW    = 255;
  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned INDEX_BITS    = 16;
  localparam int unsigned CFG_BITS      = 8;
  localparam int unsigned WINDOW_RESET  = 5;

  localparam int unsigned PTR_BITS      = $clog2(MAX_WINDOW);
  localparam int unsigned LEN_BITS      = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_BITS      = SAMPLE_BITS + LEN_BITS;

  localparam int unsigned BITS_PER_STEP = 2;
  localparam int unsigned DIV_STEPS     = (SUM_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int unsigned DIV_BITS      = DIV_STEPS * BITS_PER_STEP;
  localparam int unsigned STEP_BITS     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  typedef struct packed {
    logic accept;
    logic update;
    logic div_load;
    logic div_step;
    logic finish;
  } spd_cmd_t;

  typedef struct packed {
    logic result_due;
    logic out_free;
  } spd_status_t;

  // zero -> 1, cap at MAX_WINDOW, even -> next lower odd
  function automatic logic [LEN_BITS-1:0] effective_len(input logic [CFG_BITS-1:0] w);
    int unsigned v;
    v = int'(w);
    if (v == 0) v = 1;
    if (v > MAX_WINDOW) v = MAX_WINDOW;
    if ((v % 2) == 0) v = v - 1;
    return LEN_BITS'(v);
  endfunction

endpackage

/* src/smoothed_peak_detector_top.sv */
// Smoothed peak detector: boxcar moving average over an odd window with peak marking.
// Input channel: in_valid_i / in_stall_o carries sample_i and last_sample_i; a beat
// moves when valid is high and stall is low. Output channel: out_valid_o / out_stall_i
// carries centre_index_o, average_o, previous_is_peak_o and series_end_o.
// Configuration: cfg_we_i writes cfg_wdata_i as the window length and clears the
// series; write only while the block is idle.
// Each accepted sample is taken in the idle state, where a ring read is issued, then
// updates the ring and the sum and, once the window is full, passes through a divider
// load, the steps of the radix-4 restoring divider and a final step that loads the
// output register; in_stall_o stays high until the block is back in idle.
// The result is valid in the cycle after the output load.
// The next sample is taken while a result waits in the output register; if the
// receiver still stalls when the next result is ready, the block holds it and keeps
// in_stall_o high.
// Reset clears the series state, sets the window length to 5 and drops any result.
module smoothed_peak_detector_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [spd_pkg::CFG_BITS-1:0]           cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [spd_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                   last_sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [spd_pkg::INDEX_BITS-1:0]         centre_index_o,
  output logic signed [spd_pkg::SAMPLE_BITS-1:0] average_o,
  output logic                                   previous_is_peak_o,
  output logic                                   series_end_o
);

  spd_pkg::spd_cmd_t    cmd;
  spd_pkg::spd_status_t status;

  spd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  spd_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .sample_i          (sample_i),
    .last_sample_i     (last_sample_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .centre_index_o    (centre_index_o),
    .average_o         (average_o),
    .previous_is_peak_o(previous_is_peak_o),
    .series_end_o      (series_end_o)
  );

endmodule

/* src/spd_ram.sv */
module spd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/spd_ctrl.sv */
module spd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  spd_pkg::spd_status_t status_i,
  output spd_pkg::spd_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]                     state_q, state_d;
  logic [spd_pkg::STEP_BITS-1:0]  step_q, step_d;
  logic                           last_step;

  assign last_step = (step_q == spd_pkg::STEP_BITS'(spd_pkg::DIV_STEPS - 1));

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_UPD;
      end
      S_UPD: begin
        state_d = status_i.result_due ? S_LOAD : S_IDLE;
      end
      S_LOAD: begin
        state_d = S_DIV;
        step_d  = '0;
      end
      S_DIV: begin
        step_d = step_q + 1'b1;
        if (last_step) state_d = S_FIN;
      end
      S_FIN: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign cmd_o.accept    = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.update    = (state_q == S_UPD);
  assign cmd_o.div_load  = (state_q == S_LOAD);
  assign cmd_o.div_step  = (state_q == S_DIV);
  assign cmd_o.finish    = (state_q == S_FIN) && status_i.out_free;

`ifndef SYNTH
  a_accept_to_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == S_UPD))
    else $error("accepted beat did not enter update");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (step_q <= spd_pkg::STEP_BITS'(spd_pkg::DIV_STEPS - 1)))
    else $error("divide step count overran");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_load |=> (step_q == '0) && (state_q == S_DIV))
    else $error("divide did not start from step zero");

  a_fin_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) && !status_i.out_free |=> (state_q == S_FIN))
    else $error("result left before output register was free");
`endif

endmodule

/* src/spd_datapath.sv */
module spd_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [spd_pkg::CFG_BITS-1:0]         cfg_wdata_i,
  input  logic signed [spd_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                 last_sample_i,
  input  spd_pkg::spd_cmd_t                    cmd_i,
  output spd_pkg::spd_status_t                 status_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [spd_pkg::INDEX_BITS-1:0]       centre_index_o,
  output logic signed [spd_pkg::SAMPLE_BITS-1:0] average_o,
  output logic                                 previous_is_peak_o,
  output logic                                 series_end_o
);

  localparam int unsigned SB = spd_pkg::SAMPLE_BITS;
  localparam int unsigned LB = spd_pkg::LEN_BITS;
  localparam int unsigned PB = spd_pkg::PTR_BITS;
  localparam int unsigned UB = spd_pkg::SUM_BITS;
  localparam int unsigned IB = spd_pkg::INDEX_BITS;
  localparam int unsigned DB = spd_pkg::DIV_BITS;

  // series state
  logic [LB-1:0]        len_q;
  logic [PB-1:0]        ptr_q;
  logic signed [UB-1:0] sum_q;
  logic [IB-1:0]        seen_q;
  logic [LB-1:0]        fill_q;
  logic signed [UB-1:0] prev_q;
  logic                 rising_q;
  logic                 have_prev_q;

  // beat in flight
  logic [SB-1:0]        sample_q;
  logic                 last_q;
  logic [IB-1:0]        newest_q;

  // divider
  logic [DB-1:0]        dvd_q;
  logic [LB-1:0]        rem_q;
  logic                 neg_q;

  // output register
  logic                 out_valid_q;
  logic [IB-1:0]        centre_q;
  logic [SB-1:0]        avg_q;
  logic                 peak_q;
  logic                 end_q;

  logic [SB-1:0]        old_sample;
  logic [PB-1:0]        ptr_eff;
  logic [LB-1:0]        ptr_inc;
  logic [PB-1:0]        ptr_next;
  logic [LB-1:0]        fill_next;
  logic                 sub_old;
  logic signed [UB-1:0] old_ext;
  logic signed [UB-1:0] new_ext;
  logic signed [UB-1:0] sum_next;
  logic [UB-1:0]        sum_abs;
  logic [LB-1:0]        rem_v;
  logic [DB-1:0]        dvd_v;
  logic [LB:0]          trial;
  logic [SB-1:0]        quot;
  logic                 peak_now;

  spd_ram #(
    .WIDTH(SB),
    .DEPTH(spd_pkg::MAX_WINDOW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (cmd_i.update),
    .waddr_i(ptr_eff),
    .wdata_i(sample_q),
    .re_i   (cmd_i.accept),
    .raddr_i(ptr_eff),
    .rdata_o(old_sample)
  );

  assign ptr_eff   = (LB'(ptr_q) >= len_q) ? '0 : ptr_q;
  assign ptr_inc   = LB'(ptr_eff) + 1'b1;
  assign ptr_next  = (ptr_inc >= len_q) ? '0 : PB'(ptr_inc);
  assign sub_old   = (fill_q >= len_q);
  assign fill_next = (fill_q < LB'(spd_pkg::MAX_WINDOW)) ? fill_q + 1'b1 : fill_q;
  assign old_ext   = {{(UB-SB){old_sample[SB-1]}}, old_sample};
  assign new_ext   = {{(UB-SB){sample_q[SB-1]}}, sample_q};
  assign sum_next  = sum_q - (sub_old ? old_ext : '0) + new_ext;
  assign sum_abs   = sum_q[UB-1] ? (~sum_q + 1'b1) : sum_q;
  assign quot      = dvd_q[SB-1:0];
  assign peak_now  = have_prev_q && rising_q && (sum_q <= prev_q);

  // restoring divide, BITS_PER_STEP quotient bits per cycle
  always_comb begin
    rem_v = rem_q;
    dvd_v = dvd_q;
    trial = '0;
    for (int k = 0; k < spd_pkg::BITS_PER_STEP; k++) begin
      trial = {rem_v, dvd_v[DB-1]};
      dvd_v = {dvd_v[DB-2:0], 1'b0};
      if (trial >= {1'b0, len_q}) begin
        trial    = trial - {1'b0, len_q};
        dvd_v[0] = 1'b1;
      end
      rem_v = trial[LB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= spd_pkg::effective_len(spd_pkg::CFG_BITS'(spd_pkg::WINDOW_RESET));
      ptr_q       <= '0;
      sum_q       <= '0;
      seen_q      <= '0;
      fill_q      <= '0;
      prev_q      <= '0;
      rising_q    <= 1'b0;
      have_prev_q <= 1'b0;
    end else if (cfg_we_i) begin
      len_q       <= spd_pkg::effective_len(cfg_wdata_i);
      ptr_q       <= '0;
      sum_q       <= '0;
      seen_q      <= '0;
      fill_q      <= '0;
      prev_q      <= '0;
      rising_q    <= 1'b0;
      have_prev_q <= 1'b0;
    end else if (cmd_i.update) begin
      if (last_q && !(fill_next >= len_q)) begin
        ptr_q       <= '0;
        sum_q       <= '0;
        seen_q      <= '0;
        fill_q      <= '0;
        prev_q      <= '0;
        rising_q    <= 1'b0;
        have_prev_q <= 1'b0;
      end else begin
        ptr_q  <= ptr_next;
        sum_q  <= sum_next;
        seen_q <= seen_q + 1'b1;
        fill_q <= fill_next;
      end
    end else if (cmd_i.finish) begin
      if (last_q) begin
        ptr_q       <= '0;
        sum_q       <= '0;
        seen_q      <= '0;
        fill_q      <= '0;
        prev_q      <= '0;
        rising_q    <= 1'b0;
        have_prev_q <= 1'b0;
      end else begin
        if (have_prev_q) rising_q <= (sum_q >= prev_q);
        prev_q      <= sum_q;
        have_prev_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_i;
      last_q   <= last_sample_i;
    end
    if (cmd_i.update) begin
      newest_q <= seen_q;
    end
    if (cmd_i.div_load) begin
      dvd_q <= DB'(sum_abs);
      rem_q <= '0;
      neg_q <= sum_q[UB-1];
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_v;
      rem_q <= rem_v;
    end
    if (cmd_i.finish) begin
      centre_q <= newest_q - IB'((len_q - 1'b1) >> 1);
      avg_q    <= neg_q ? (~quot + 1'b1) : quot;
      peak_q   <= peak_now;
      end_q    <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.result_due = (fill_next >= len_q);
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o        = out_valid_q;
  assign centre_index_o     = centre_q;
  assign average_o          = avg_q;
  assign previous_is_peak_o = peak_q;
  assign series_end_o       = end_q;

`ifndef SYNTH
  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q)
    else $error("finished result not presented");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrote a stalled beat");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> (LB'(ptr_eff) < len_q))
    else $error("ring pointer outside window");
`endif

endmodule
